@@ rtl/aarm_pkg.sv @@
`timescale 1ns / 1ps

package aarm_pkg;

    localparam int COORD_WIDTH     = 18;
    localparam int ANGLE_WIDTH     = 16;
    localparam int TRIG_ITERATIONS = 16;

    localparam int ATAN_LEN   = 24;
    localparam int TRIG_STEPS = (TRIG_ITERATIONS > ATAN_LEN) ? ATAN_LEN : TRIG_ITERATIONS;

    localparam int OUT_WIDTH    = 18;
    localparam int MAG_WIDTH    = 32;
    localparam int SHIFT_WIDTH  = 5;
    localparam int ROOT_WIDTH   = 64;
    localparam int ROOT_STEPS   = ROOT_WIDTH / 2;
    localparam int QUO_WIDTH    = 31;
    localparam int REM_WIDTH    = 63;
    localparam int CORDIC_WIDTH = 34;
    localparam int PROD_WIDTH   = 64;
    localparam int TERM_WIDTH   = 34;
    localparam int SUM_WIDTH    = 35;
    localparam int ENTRY_WIDTH  = 36;

    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 34'sh26DD3B6A;
    localparam logic [QUO_WIDTH-1:0]           Q30_ONE     = 31'h4000_0000;
    localparam logic signed [PROD_WIDTH-1:0]   OUT_MAX     = 64'sd131071;
    localparam logic signed [PROD_WIDTH-1:0]   OUT_MIN     = -64'sd131072;

    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [ROOT_WIDTH-1:0] rem;
        logic [ROOT_WIDTH-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [REM_WIDTH-1:0] rem;
        logic [QUO_WIDTH-1:0] quo;
    } div_t;

    typedef struct packed {
        logic signed [CORDIC_WIDTH-1:0] z;
        logic                           neg;
    } trig_t;

    function automatic logic [MAG_WIDTH-1:0] magnitude(logic signed [COORD_WIDTH-1:0] a);
        logic signed [MAG_WIDTH:0] w;
        w = (MAG_WIDTH+1)'(a);
        if (w < 0)
        begin
            w = -w;
        end
        return w[MAG_WIDTH-1:0];
    endfunction

    // left shift that brings the top set bit of the largest magnitude to bit 30
    function automatic logic [SHIFT_WIDTH-1:0] norm_shift(logic [MAG_WIDTH-1:0] m);
        logic [SHIFT_WIDTH-1:0] s;
        s = '0;
        for (int k = 0; k < MAG_WIDTH - 1; k++)
        begin
            if (m[k])
            begin
                s = SHIFT_WIDTH'(MAG_WIDTH - 2 - k);
            end
        end
        return s;
    endfunction

    // one digit of the bit-pair square root
    function automatic sqrt_t sqrt_step(sqrt_t cur, int pos);
        logic [ROOT_WIDTH-1:0] trial;
        sqrt_t                 nxt;
        trial = cur.root + (ROOT_WIDTH'(1) << pos);
        if (cur.rem >= trial)
        begin
            nxt.rem  = cur.rem - trial;
            nxt.root = (cur.root >> 1) + (ROOT_WIDTH'(1) << pos);
        end
        else
        begin
            nxt.rem  = cur.rem;
            nxt.root = cur.root >> 1;
        end
        return nxt;
    endfunction

    // one quotient bit of the restoring divider
    function automatic div_t div_step(div_t cur, logic [MAG_WIDTH-1:0] den, int pos);
        logic [REM_WIDTH-1:0] part;
        div_t                 nxt;
        part = REM_WIDTH'(den) << pos;
        nxt  = cur;
        if (cur.rem >= part)
        begin
            nxt.rem = cur.rem - part;
            nxt.quo = cur.quo | (QUO_WIDTH'(1) << pos);
        end
        return nxt;
    endfunction

    function automatic logic signed [MAG_WIDTH-1:0] unit_comp(logic [QUO_WIDTH-1:0] q,
                                                              logic neg);
        logic signed [MAG_WIDTH-1:0] m;
        m = (q > Q30_ONE) ? $signed(MAG_WIDTH'(Q30_ONE)) : $signed(MAG_WIDTH'(q));
        return neg ? -m : m;
    endfunction

    // fold the angle into [-quarter, quarter) and remember the sign flip
    function automatic trig_t trig_reduce(logic [ANGLE_WIDTH-1:0] ang);
        logic [31:0] a;
        trig_t       r;
        a     = 32'(ang) << (32 - ANGLE_WIDTH);
        r.neg = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (r.neg)
        begin
            a[31] = ~a[31];
        end
        r.z = CORDIC_WIDTH'($signed(a));
        return r;
    endfunction

    function automatic logic signed [PROD_WIDTH-1:0] rnd(logic signed [PROD_WIDTH-1:0] v,
                                                         int s);
        return (v + (PROD_WIDTH'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] sat_out(logic signed [PROD_WIDTH-1:0] e);
        logic signed [PROD_WIDTH-1:0] r;
        r = rnd(e, 14);
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
        end
        if (r < OUT_MIN)
        begin
            r = OUT_MIN;
        end
        return r[OUT_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/axis_angle_rotation_matrix.sv @@
`timescale 1ns / 1ps

// Axis-angle to 3x3 rotation matrix (Rodrigues form R = c*I + (1-c)*n*n^T + s*[n]x).
// Feed any nonzero axis and an angle (full circle = 2^ANGLE_WIDTH); the block returns the
// nine entries in signed Q1.16, rounded and saturated, with zero_axis set and all entries
// zero when the axis is zero. It is a fixed pipeline of 79 register stages; one transaction
// enters every cycle while the output side is not stalled. Most of the depth lies in the
// 32-stage square root and the 31-stage dividers that normalize the axis, one result bit
// per stage; the CORDIC runs alongside them. When the output transaction is stalled the
// whole pipeline holds and in_stall goes high in the same cycle.
module axis_angle_rotation_matrix
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [aarm_pkg::COORD_WIDTH-1:0]   axis_x,
    input  logic signed [aarm_pkg::COORD_WIDTH-1:0]   axis_y,
    input  logic signed [aarm_pkg::COORD_WIDTH-1:0]   axis_z,
    input  logic        [aarm_pkg::ANGLE_WIDTH-1:0]   angle,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m00,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m01,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m02,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m10,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m11,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m12,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m20,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m21,
    output logic signed [aarm_pkg::OUT_WIDTH-1:0]     m22,
    output logic                                      zero_axis
);

    localparam int MW = aarm_pkg::MAG_WIDTH;
    localparam int SW = aarm_pkg::SHIFT_WIDTH;
    localparam int RW = aarm_pkg::REM_WIDTH;
    localparam int QW = aarm_pkg::QUO_WIDTH;
    localparam int CW = aarm_pkg::CORDIC_WIDTH;
    localparam int PW = aarm_pkg::PROD_WIDTH;
    localparam int TW = aarm_pkg::TERM_WIDTH;
    localparam int AW = aarm_pkg::SUM_WIDTH;
    localparam int EW = aarm_pkg::ENTRY_WIDTH;
    localparam int OW = aarm_pkg::OUT_WIDTH;
    localparam int TS = aarm_pkg::TRIG_STEPS;

    // stage map: each name is the stage whose registers hold that value
    localparam int ST_IN    = 0;                           // raw input transaction
    localparam int ST_MAG   = ST_IN + 1;                   // magnitudes, signs, zero flag
    localparam int ST_MAX   = ST_MAG + 1;                  // largest magnitude
    localparam int ST_LZC   = ST_MAX + 1;                  // normalize shift
    localparam int ST_SHF   = ST_LZC + 1;                  // shifted magnitudes
    localparam int ST_SQR   = ST_SHF + 1;                  // squares
    localparam int ST_SUM   = ST_SQR + 1;                  // sum of squares
    localparam int ST_ROOT  = ST_SUM + aarm_pkg::ROOT_STEPS; // floor square root
    localparam int ST_DIVI  = ST_ROOT + 1;                 // rounded dividends
    localparam int ST_QUO   = ST_DIVI + QW;                // quotients
    localparam int ST_UNIT  = ST_QUO + 1;                  // unit axis, cosine, sine
    localparam int ST_M1    = ST_UNIT + 1;                 // axis products
    localparam int ST_M2    = ST_M1 + 1;                   // rounded, sine products
    localparam int ST_M3    = ST_M2 + 1;                   // diagonal sums
    localparam int ST_M4    = ST_M3 + 1;                   // cosine products
    localparam int ST_M5    = ST_M4 + 1;                   // rounded terms
    localparam int ST_M6    = ST_M5 + 1;                   // Q30 entries
    localparam int ST_OUT   = ST_M6 + 1;                   // Q1.16 output register
    localparam int DEPTH    = ST_OUT + 1;
    localparam int ST_TRIG  = ST_UNIT - TS - 1;            // reduced angle, CORDIC seed

    logic             adv;
    logic [DEPTH-1:0] vld_reg;

    logic signed [aarm_pkg::COORD_WIDTH-1:0] axis_reg [3];
    logic [aarm_pkg::ANGLE_WIDTH-1:0]        ang_reg  [ST_IN:ST_TRIG-1];
    logic                                    zro_reg  [ST_MAG:ST_M6];
    logic [2:0]                              sgn_reg  [ST_MAG:ST_QUO];

    logic [MW-1:0]          mag_reg [ST_MAG:ST_LZC][3];
    logic [MW-1:0]          max_reg;
    logic [SW-1:0]          shamt_reg;
    logic [MW-1:0]          shf_reg [ST_SHF:ST_ROOT][3];
    logic [2*MW-1:0]        sq_reg  [3];
    aarm_pkg::sqrt_t        rt_reg  [ST_SUM:ST_ROOT];
    aarm_pkg::div_t         dv_reg  [ST_DIVI:ST_QUO][3];
    logic [MW-1:0]          den_reg [ST_DIVI:ST_QUO-1];

    aarm_pkg::trig_t        tr_reg  [ST_TRIG:ST_UNIT-1];
    logic signed [CW-1:0]   cx_reg  [ST_TRIG:ST_UNIT-1];
    logic signed [CW-1:0]   cy_reg  [ST_TRIG:ST_UNIT-1];

    logic signed [MW-1:0]   u_reg   [3];
    logic signed [CW-1:0]   c0_reg;
    logic signed [CW-1:0]   s0_reg;

    logic signed [PW-1:0]   pm1_reg [6];
    logic signed [MW-1:0]   u1_reg  [3];
    logic signed [CW-1:0]   c1_reg;
    logic signed [CW-1:0]   s1_reg;

    logic signed [TW-1:0]   sq2_reg [3];
    logic signed [TW-1:0]   cr2_reg [3];
    logic signed [PW-1:0]   ps2_reg [3];
    logic signed [CW-1:0]   c2_reg;
    logic signed [AW-1:0]   cc2_reg;

    logic signed [AW-1:0]   sm3_reg [3];
    logic signed [TW-1:0]   sq3_reg [3];
    logic signed [TW-1:0]   cr3_reg [3];
    logic signed [TW-1:0]   ps3_reg [3];
    logic signed [CW-1:0]   c3_reg;
    logic signed [AW-1:0]   cc3_reg;

    logic signed [PW-1:0]   pd4_reg [3];
    logic signed [PW-1:0]   pt4_reg [3];
    logic signed [TW-1:0]   sq4_reg [3];
    logic signed [TW-1:0]   ps4_reg [3];

    logic signed [TW-1:0]   d5_reg  [3];
    logic signed [TW-1:0]   t5_reg  [3];
    logic signed [TW-1:0]   sq5_reg [3];
    logic signed [TW-1:0]   ps5_reg [3];

    logic signed [EW-1:0]   e6_reg  [9];
    logic [OW-1:0]          out_reg [9];
    logic                   zero_reg;

    // the pipeline moves as one; it holds only while a finished transaction waits
    assign adv       = !(vld_reg[ST_OUT] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // capture
            axis_reg[0]    <= axis_x;
            axis_reg[1]    <= axis_y;
            axis_reg[2]    <= axis_z;
            ang_reg[ST_IN] <= angle;
            for (int k = ST_IN + 1; k < ST_TRIG; k++)
            begin
                ang_reg[k] <= ang_reg[k-1];
            end

            // magnitudes and side flags
            zro_reg[ST_MAG] <= (axis_reg[0] == '0) && (axis_reg[1] == '0)
                               && (axis_reg[2] == '0);
            for (int k = ST_MAG + 1; k <= ST_M6; k++)
            begin
                zro_reg[k] <= zro_reg[k-1];
            end
            sgn_reg[ST_MAG] <= {axis_reg[2][aarm_pkg::COORD_WIDTH-1],
                                axis_reg[1][aarm_pkg::COORD_WIDTH-1],
                                axis_reg[0][aarm_pkg::COORD_WIDTH-1]};
            for (int k = ST_MAG + 1; k <= ST_QUO; k++)
            begin
                sgn_reg[k] <= sgn_reg[k-1];
            end
            for (int n = 0; n < 3; n++)
            begin
                mag_reg[ST_MAG][n] <= aarm_pkg::magnitude(axis_reg[n]);
                mag_reg[ST_MAX][n] <= mag_reg[ST_MAG][n];
                mag_reg[ST_LZC][n] <= mag_reg[ST_MAX][n];
            end

            // normalize so the top bit of the largest magnitude sits at bit 30
            max_reg <= (mag_reg[ST_MAG][0] > mag_reg[ST_MAG][1])
                       ? ((mag_reg[ST_MAG][0] > mag_reg[ST_MAG][2])
                          ? mag_reg[ST_MAG][0] : mag_reg[ST_MAG][2])
                       : ((mag_reg[ST_MAG][1] > mag_reg[ST_MAG][2])
                          ? mag_reg[ST_MAG][1] : mag_reg[ST_MAG][2]);
            shamt_reg <= aarm_pkg::norm_shift(max_reg);
            for (int n = 0; n < 3; n++)
            begin
                shf_reg[ST_SHF][n] <= mag_reg[ST_LZC][n] << shamt_reg;
                for (int k = ST_SHF + 1; k <= ST_ROOT; k++)
                begin
                    shf_reg[k][n] <= shf_reg[k-1][n];
                end
                sq_reg[n] <= shf_reg[ST_SHF][n] * shf_reg[ST_SHF][n];
            end

            // vector length: one root digit per stage
            rt_reg[ST_SUM].rem  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rt_reg[ST_SUM].root <= '0;
            for (int j = 0; j < aarm_pkg::ROOT_STEPS; j++)
            begin
                rt_reg[ST_SUM+1+j] <= aarm_pkg::sqrt_step(rt_reg[ST_SUM+j],
                                                          2 * aarm_pkg::ROOT_STEPS - 2 - 2 * j);
            end

            // unit components: one quotient bit per stage, rounded half up
            den_reg[ST_DIVI] <= rt_reg[ST_ROOT].root[MW-1:0];
            for (int k = ST_DIVI + 1; k < ST_QUO; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
            for (int n = 0; n < 3; n++)
            begin
                dv_reg[ST_DIVI][n].rem <= (RW'(shf_reg[ST_ROOT][n]) << (QW - 1))
                                          + RW'(rt_reg[ST_ROOT].root[MW-1:1]);
                dv_reg[ST_DIVI][n].quo <= '0;
                for (int j = 0; j < QW; j++)
                begin
                    dv_reg[ST_DIVI+1+j][n] <= aarm_pkg::div_step(dv_reg[ST_DIVI+j][n],
                                                                 den_reg[ST_DIVI+j],
                                                                 QW - 1 - j);
                end
                u_reg[n] <= aarm_pkg::unit_comp(dv_reg[ST_QUO][n].quo, sgn_reg[ST_QUO][n]);
            end

            // CORDIC, timed to land beside the unit axis
            tr_reg[ST_TRIG] <= aarm_pkg::trig_reduce(ang_reg[ST_TRIG-1]);
            cx_reg[ST_TRIG] <= aarm_pkg::CORDIC_GAIN;
            cy_reg[ST_TRIG] <= '0;
            for (int k = 0; k < TS; k++)
            begin
                tr_reg[ST_TRIG+1+k].neg <= tr_reg[ST_TRIG+k].neg;
                if (!tr_reg[ST_TRIG+k].z[CW-1])
                begin
                    cx_reg[ST_TRIG+1+k]   <= cx_reg[ST_TRIG+k] - (cy_reg[ST_TRIG+k] >>> k);
                    cy_reg[ST_TRIG+1+k]   <= cy_reg[ST_TRIG+k] + (cx_reg[ST_TRIG+k] >>> k);
                    tr_reg[ST_TRIG+1+k].z <= tr_reg[ST_TRIG+k].z
                                             - $signed(CW'(aarm_pkg::ATAN_TAB[k]));
                end
                else
                begin
                    cx_reg[ST_TRIG+1+k]   <= cx_reg[ST_TRIG+k] + (cy_reg[ST_TRIG+k] >>> k);
                    cy_reg[ST_TRIG+1+k]   <= cy_reg[ST_TRIG+k] - (cx_reg[ST_TRIG+k] >>> k);
                    tr_reg[ST_TRIG+1+k].z <= tr_reg[ST_TRIG+k].z
                                             + $signed(CW'(aarm_pkg::ATAN_TAB[k]));
                end
            end
            c0_reg <= tr_reg[ST_UNIT-1].neg ? -cx_reg[ST_UNIT-1] : cx_reg[ST_UNIT-1];
            s0_reg <= tr_reg[ST_UNIT-1].neg ? -cy_reg[ST_UNIT-1] : cy_reg[ST_UNIT-1];

            // M1: squares and cross products of the unit axis
            pm1_reg[0] <= u_reg[0] * u_reg[0];
            pm1_reg[1] <= u_reg[1] * u_reg[1];
            pm1_reg[2] <= u_reg[2] * u_reg[2];
            pm1_reg[3] <= u_reg[0] * u_reg[1];
            pm1_reg[4] <= u_reg[0] * u_reg[2];
            pm1_reg[5] <= u_reg[1] * u_reg[2];
            for (int n = 0; n < 3; n++)
            begin
                u1_reg[n] <= u_reg[n];
            end
            c1_reg <= c0_reg;
            s1_reg <= s0_reg;

            // M2: round, start the sine terms, form 1 - c
            for (int n = 0; n < 3; n++)
            begin
                sq2_reg[n] <= TW'(aarm_pkg::rnd(pm1_reg[n], 30));
                cr2_reg[n] <= TW'(aarm_pkg::rnd(pm1_reg[n+3], 30));
                ps2_reg[n] <= u1_reg[n] * s1_reg;
            end
            c2_reg  <= c1_reg;
            cc2_reg <= (35'sd1 <<< 30) - c1_reg;

            // M3: off-axis sums for the diagonal
            sm3_reg[0] <= sq2_reg[1] + sq2_reg[2];
            sm3_reg[1] <= sq2_reg[0] + sq2_reg[2];
            sm3_reg[2] <= sq2_reg[0] + sq2_reg[1];
            for (int n = 0; n < 3; n++)
            begin
                sq3_reg[n] <= sq2_reg[n];
                cr3_reg[n] <= cr2_reg[n];
                ps3_reg[n] <= TW'(aarm_pkg::rnd(ps2_reg[n], 30));
            end
            c3_reg  <= c2_reg;
            cc3_reg <= cc2_reg;

            // M4: cosine products
            for (int n = 0; n < 3; n++)
            begin
                pd4_reg[n] <= sm3_reg[n] * c3_reg;
                pt4_reg[n] <= cr3_reg[n] * cc3_reg;
                sq4_reg[n] <= sq3_reg[n];
                ps4_reg[n] <= ps3_reg[n];
            end

            // M5: round
            for (int n = 0; n < 3; n++)
            begin
                d5_reg[n]  <= TW'(aarm_pkg::rnd(pd4_reg[n], 30));
                t5_reg[n]  <= TW'(aarm_pkg::rnd(pt4_reg[n], 30));
                sq5_reg[n] <= sq4_reg[n];
                ps5_reg[n] <= ps4_reg[n];
            end

            // M6: entries in Q30, row major; ps5 holds u*s, v*s, w*s
            e6_reg[0] <= sq5_reg[0] + d5_reg[0];
            e6_reg[1] <= t5_reg[0] - ps5_reg[2];
            e6_reg[2] <= t5_reg[1] + ps5_reg[1];
            e6_reg[3] <= t5_reg[0] + ps5_reg[2];
            e6_reg[4] <= sq5_reg[1] + d5_reg[1];
            e6_reg[5] <= t5_reg[2] - ps5_reg[0];
            e6_reg[6] <= t5_reg[1] - ps5_reg[1];
            e6_reg[7] <= t5_reg[2] + ps5_reg[0];
            e6_reg[8] <= sq5_reg[2] + d5_reg[2];

            // output: round to Q1.16, saturate, drop everything for a zero axis
            for (int n = 0; n < 9; n++)
            begin
                out_reg[n] <= zro_reg[ST_M6] ? '0 : aarm_pkg::sat_out(PW'(e6_reg[n]));
            end
            zero_reg <= zro_reg[ST_M6];
        end
    end

    assign m00       = $signed(out_reg[0]);
    assign m01       = $signed(out_reg[1]);
    assign m02       = $signed(out_reg[2]);
    assign m10       = $signed(out_reg[3]);
    assign m11       = $signed(out_reg[4]);
    assign m12       = $signed(out_reg[5]);
    assign m20       = $signed(out_reg[6]);
    assign m21       = $signed(out_reg[7]);
    assign m22       = $signed(out_reg[8]);
    assign zero_axis = zero_reg;

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_axis |-> m00 == '0 && m01 == '0 && m11 == '0 && m22 == '0)
        else $error("zero axis transaction with nonzero entries");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_ROOT] && !zro_reg[ST_ROOT]
        |-> rt_reg[ST_ROOT].root >= (64'd1 << 30) && rt_reg[ST_ROOT].root < (64'd1 << 32))
        else $error("axis length outside normalized range");

    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_QUO] && !zro_reg[ST_QUO]
        |-> dv_reg[ST_QUO][0].quo <= aarm_pkg::Q30_ONE
            && dv_reg[ST_QUO][1].quo <= aarm_pkg::Q30_ONE
            && dv_reg[ST_QUO][2].quo <= aarm_pkg::Q30_ONE)
        else $error("unit component above one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while held");

endmodule

@@ tb/tb_axis_angle_rotation_matrix.sv @@
`timescale 1ns / 1ps

module tb_axis_angle_rotation_matrix;

    localparam int COORD_WIDTH = aarm_pkg::COORD_WIDTH;
    localparam int ANGLE_WIDTH = aarm_pkg::ANGLE_WIDTH;
    localparam int OUT_WIDTH   = aarm_pkg::OUT_WIDTH;
    localparam int TRIG_STEPS  = aarm_pkg::TRIG_STEPS;

    // Pipeline depth from the block header; used for the end-of-run wait.
    localparam int PIPE_DEPTH = 79;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] ent [9];
        logic                        zflag;
    } rot_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [COORD_WIDTH-1:0] axis_x;
    logic signed [COORD_WIDTH-1:0] axis_y;
    logic signed [COORD_WIDTH-1:0] axis_z;
    logic [ANGLE_WIDTH-1:0] angle;
    logic out_valid;
    logic out_stall;
    logic signed [OUT_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic zero_axis;

    // Expected matrices, oldest at the front.
    rot_t matrix_q[$];

    int errors = 0;
    int sent = 0;
    int checked = 0;
    int zero_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    axis_angle_rotation_matrix uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .m00(m00), .m01(m01), .m02(m02),
        .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .zero_axis(zero_axis)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Floor division by 2^s, valid for either sign.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return round_q(a * b, 30);
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] to_q16(longint q30);
        longint r;
        r = round_q(q30, 14);
        if (r > 131071)
        begin
            r = 131071;
        end
        if (r < -131072)
        begin
            r = -131072;
        end
        return OUT_WIDTH'(r);
    endfunction

    // Integer square root, floor, of a 64-bit value.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
        begin
            bitv >>= 2;
        end
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_q30(longint a, longint unsigned len);
        longint unsigned q;
        longint unsigned m;
        m = (a < 0) ? longint'(-a) : longint'(a);
        q = ((m << 30) + (len >> 1)) / len;
        if (q > (64'd1 << 30))
        begin
            q = 64'd1 << 30;
        end
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Rodrigues rotation: normalize the axis, CORDIC for cos/sin, then combine.
    function automatic rot_t rodrigues(logic signed [COORD_WIDTH-1:0] ix,
                                       logic signed [COORD_WIDTH-1:0] iy,
                                       logic signed [COORD_WIDTH-1:0] iz,
                                       logic [ANGLE_WIDTH-1:0] ang);
        rot_t r;
        longint ax, ay, az, u, v, w, x, y, z, c, sn, cc, uu, vv, ww, t, p, dx, dy;
        longint unsigned mx, len;
        logic [31:0] a32;
        logic flip;
        int sh;
        ax = ix;
        ay = iy;
        az = iz;
        if (ax == 0 && ay == 0 && az == 0)
        begin
            foreach (r.ent[k])
            begin
                r.ent[k] = '0;
            end
            r.zflag = 1'b1;
            return r;
        end
        mx = (ax < 0) ? -ax : ax;
        if (((ay < 0) ? -ay : ay) > mx)
        begin
            mx = (ay < 0) ? -ay : ay;
        end
        if (((az < 0) ? -az : az) > mx)
        begin
            mx = (az < 0) ? -az : az;
        end
        sh = 0;
        while ((mx << sh) < (64'd1 << 30))
        begin
            sh++;
        end
        ax = ax <<< sh;
        ay = ay <<< sh;
        az = az <<< sh;
        len = int_sqrt(ax * ax + ay * ay + az * az);
        u = unit_q30(ax, len);
        v = unit_q30(ay, len);
        w = unit_q30(az, len);

        a32 = 32'(ang) << (32 - ANGLE_WIDTH);
        flip = (a32[31:30] == 2'b01) || (a32[31:30] == 2'b10);
        if (flip)
        begin
            a32 = a32 - 32'h8000_0000;
        end
        z = longint'($signed(a32));
        x = 64'sh26DD3B6A;
        y = 0;
        for (int i = 0; i < TRIG_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(aarm_pkg::ATAN_TAB[i]);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(aarm_pkg::ATAN_TAB[i]);
            end
        end
        c = flip ? -x : x;
        sn = flip ? -y : y;
        cc = (longint'(1) << 30) - c;
        uu = mul_q30(u, u);
        vv = mul_q30(v, v);
        ww = mul_q30(w, w);
        r.ent[0] = to_q16(uu + mul_q30(vv + ww, c));
        r.ent[4] = to_q16(vv + mul_q30(uu + ww, c));
        r.ent[8] = to_q16(ww + mul_q30(uu + vv, c));
        t = mul_q30(mul_q30(u, v), cc);
        p = mul_q30(w, sn);
        r.ent[1] = to_q16(t - p);
        r.ent[3] = to_q16(t + p);
        t = mul_q30(mul_q30(u, w), cc);
        p = mul_q30(v, sn);
        r.ent[2] = to_q16(t + p);
        r.ent[6] = to_q16(t - p);
        t = mul_q30(mul_q30(v, w), cc);
        p = mul_q30(u, sn);
        r.ent[5] = to_q16(t - p);
        r.ent[7] = to_q16(t + p);
        r.zflag = 1'b0;
        return r;
    endfunction

    // Drive one transaction with a random idle gap ahead of it; hold until accepted.
    task automatic send_axis(input logic signed [COORD_WIDTH-1:0] x,
                             input logic signed [COORD_WIDTH-1:0] y,
                             input logic signed [COORD_WIDTH-1:0] z,
                             input logic [ANGLE_WIDTH-1:0] ang);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        axis_x <= x;
        axis_y <= y;
        axis_z <= z;
        angle <= ang;
        // Predict at send time: acceptance order equals send order.
        matrix_q.push_back(rodrigues(x, y, z, ang));
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic idle_sender();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off until every expected matrix has come back.
    task automatic drain();
        idle_sender();
        while (matrix_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random stall on the result side, redrawn every cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            rot_t exp_m;
            logic signed [OUT_WIDTH-1:0] got [9];
            got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            if (matrix_q.size() == 0)
            begin
                $display("%0t: unexpected result m00=%0d", $time, m00);
                errors++;
            end
            else
            begin
                exp_m = matrix_q.pop_front();
                checked++;
                if (zero_axis)
                begin
                    zero_seen++;
                end
                for (int k = 0; k < 9; k++)
                begin
                    if (got[k] !== exp_m.ent[k])
                    begin
                        $display("%0t: m%0d%0d expected %0d actual %0d", $time,
                                 k / 3, k % 3, exp_m.ent[k], got[k]);
                        errors++;
                    end
                end
                if (zero_axis !== exp_m.zflag)
                begin
                    $display("%0t: zero_axis expected %0b actual %0b", $time,
                             exp_m.zflag, zero_axis);
                    errors++;
                end
            end
        end
    end

    // Extremes of each field, zero axis, each coordinate axis, and quadrant edges.
    task automatic test_directed();
        send_axis(0, 0, 0, 16'h1234);
        send_axis(0, 0, 0, 0);
        send_axis(18'sh1FFFF, 0, 0, 16'h4000);
        send_axis(0, 18'sh1FFFF, 0, 16'h8000);
        send_axis(0, 0, 18'sh1FFFF, 16'hC000);
        send_axis(-18'sh20000, 0, 0, 16'h2000);
        send_axis(0, -18'sh20000, 0, 16'hFFFF);
        send_axis(0, 0, -18'sh20000, 16'h3FFF);
        send_axis(-18'sh20000, -18'sh20000, -18'sh20000, 16'h7FFF);
        send_axis(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 16'hBFFF);
        send_axis(1, 0, 0, 16'h0001);
        send_axis(-1, 1, -1, 16'hC001);
        send_axis(1, 1, 1, 16'h8001);
        send_axis(18'sh1FFFF, -18'sh20000, 1, 16'h4001);
        send_axis(3, 4, 0, 16'h5555);
        send_axis(0, 0, 1, 0);
        send_axis(-5, 0, 0, 16'hAAAA);
    endtask

    // Mostly nonzero axes of mixed magnitude; a few zero axes mixed in.
    task automatic test_random(input int count);
        logic signed [COORD_WIDTH-1:0] v [3];
        int sz;
        for (int n = 0; n < count; n++)
        begin
            sz = $urandom_range(3);
            foreach (v[k])
            begin
                case (sz)
                    0: v[k] = COORD_WIDTH'($signed($urandom_range(8)) - 4);
                    1: v[k] = COORD_WIDTH'($signed($urandom_range(2000)) - 1000);
                    default: v[k] = COORD_WIDTH'($urandom);
                endcase
            end
            if ($urandom_range(39) == 0)
            begin
                v = '{0, 0, 0};
            end
            send_axis(v[0], v[1], v[2], ANGLE_WIDTH'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        axis_x = '0;
        axis_y = '0;
        axis_z = '0;
        angle = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain();

        send_idle_pct = 23;
        recv_idle_pct = 53;
        test_random(200);
        // Pause the sender until the pipeline is empty, then resume.
        drain();

        send_idle_pct = 53;
        recv_idle_pct = 23;
        test_random(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(200);
        drain();
        repeat (PIPE_DEPTH + 10) @(posedge clk);

        $display("Covered %0d transactions sent, %0d results checked, %0d zero-axis.",
                 sent, checked, zero_seen);
        $display("Phases: directed extremes, then random under both stall mixes and none.");
        if (errors == 0 && matrix_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: well above the slowest run under heavy stall.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
